@@ hw/rtl/u16550_pkg.sv @@
// Shared types and constants for the 16550-style UART register block.
package u16550_pkg;

    // Default receive FIFO depth in bytes.
    localparam int DEFAULT_FIFO_DEPTH = 16;

    // Item kinds carried on the mode field.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PUSH  = 2'd2;

    // Register offsets.
    localparam logic [2:0] ADDR_RBR = 3'd0;
    localparam logic [2:0] ADDR_IER = 3'd1;
    localparam logic [2:0] ADDR_IIR = 3'd2;
    localparam logic [2:0] ADDR_LCR = 3'd3;
    localparam logic [2:0] ADDR_MCR = 3'd4;
    localparam logic [2:0] ADDR_LSR = 3'd5;
    localparam logic [2:0] ADDR_MSR = 3'd6;
    localparam logic [2:0] ADDR_SCR = 3'd7;

    // Bit positions and register values.
    localparam int         IER_RX_READY_BIT = 0;
    localparam int         IER_TX_EMPTY_BIT = 1;
    localparam int         LCR_DLAB_BIT     = 7;
    localparam logic [7:0] IIR_NONE         = 8'h01;
    localparam logic [7:0] IIR_TX_EMPTY     = 8'h02;
    localparam logic [7:0] IIR_RX_READY     = 8'h04;
    localparam logic [7:0] LSR_DR           = 8'h01;
    localparam logic [7:0] LSR_THRE         = 8'h20;
    localparam logic [7:0] LSR_TEMT         = 8'h40;

    // Requests from the register decode to the receive FIFO.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] push_data;
    } t_fifo_req;

    // Receive FIFO status seen by the register decode.
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head;
    } t_fifo_stat;

endpackage

@@ hw/rtl/u16550_rx_fifo.sv @@
// Receive FIFO with pointers, fill count and a registered head byte.
module u16550_rx_fifo import u16550_pkg::*; #(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_req  i_req,
    output t_fifo_stat o_stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [7:0]       r_mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_head;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    // Pointer and count updates.
    always_comb begin
        n_rd_ptr = i_req.pop  ? next_slot(r_rd_ptr) : r_rd_ptr;
        n_wr_ptr = i_req.push ? next_slot(r_wr_ptr) : r_wr_ptr;
        n_count  = r_count;
        if (i_req.push && !i_req.pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_req.pop && !i_req.push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write, and a registered read of the next head entry.
    // A byte written to the slot that becomes the head is bypassed.
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_wr_ptr] <= i_req.push_data;
        end
        if (i_req.push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_req.push_data;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_stat.head  = r_head;

endmodule

@@ hw/rtl/u16550_regs.sv @@
// Register decode: IER and LCR, read mux, interrupt and transmit logic.
module u16550_regs import u16550_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_address,
    input  logic [7:0] i_write_data,
    input  t_fifo_stat i_fifo_stat,
    output t_fifo_req  o_fifo_req,
    output logic [7:0] o_read_data,
    output logic       o_push_accepted,
    output logic       o_irq_pulse,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte
);

    logic [7:0] r_ier, n_ier;
    logic [7:0] r_lcr, n_lcr;
    logic       dlab;
    logic       not_empty;

    assign dlab      = r_lcr[LCR_DLAB_BIT];
    assign not_empty = !i_fifo_stat.empty;

    // Decode of one beat into register updates, FIFO requests and the result.
    always_comb begin
        n_ier                = r_ier;
        n_lcr                = r_lcr;
        o_fifo_req.push      = 1'b0;
        o_fifo_req.pop       = 1'b0;
        o_fifo_req.push_data = i_write_data;
        o_read_data          = '0;
        o_push_accepted      = 1'b0;
        o_irq_pulse          = 1'b0;
        o_tx_valid           = 1'b0;
        o_tx_byte            = '0;
        unique case (i_mode)
            MODE_READ: begin
                unique case (i_address)
                    ADDR_RBR: begin
                        if (!dlab && not_empty) begin
                            o_read_data    = i_fifo_stat.head;
                            o_fifo_req.pop = i_fire;
                        end
                    end
                    ADDR_IER: begin
                        o_read_data = dlab ? 8'h00 : r_ier;
                    end
                    ADDR_IIR: begin
                        priority if (not_empty && r_ier[IER_RX_READY_BIT]) begin
                            o_read_data = IIR_RX_READY;
                        end else if (r_ier[IER_TX_EMPTY_BIT]) begin
                            o_read_data = IIR_TX_EMPTY;
                        end else begin
                            o_read_data = IIR_NONE;
                        end
                    end
                    ADDR_LCR: begin
                        o_read_data = r_lcr;
                    end
                    ADDR_LSR: begin
                        o_read_data = LSR_TEMT | LSR_THRE | (not_empty ? LSR_DR : 8'h00);
                    end
                    default: begin
                        o_read_data = '0;
                    end
                endcase
            end
            MODE_WRITE: begin
                if (i_address == ADDR_RBR && !dlab) begin
                    o_tx_valid = 1'b1;
                    o_tx_byte  = i_write_data;
                end else if (i_address == ADDR_IER && !dlab) begin
                    n_ier       = i_write_data;
                    o_irq_pulse = (i_write_data[IER_RX_READY_BIT] && not_empty)
                                  || i_write_data[IER_TX_EMPTY_BIT];
                end else if (i_address == ADDR_LCR) begin
                    n_lcr = i_write_data;
                end
            end
            MODE_PUSH: begin
                if (!i_fifo_stat.full) begin
                    o_fifo_req.push = i_fire;
                    o_push_accepted = 1'b1;
                    // The FIFO holds at least this byte afterwards.
                    o_irq_pulse     = r_ier[IER_RX_READY_BIT] || r_ier[IER_TX_EMPTY_BIT];
                end
            end
            default: begin
                o_read_data = '0;
            end
        endcase
    end

    // Control registers update only when a beat is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ier <= '0;
            r_lcr <= '0;
        end else if (i_fire) begin
            r_ier <= n_ier;
            r_lcr <= n_lcr;
        end
    end

endmodule

@@ hw/rtl/uart_16550_register_file_core.sv @@
// Pipeline: each input beat is held in the input register, decoded, and its result
// held in the result register until it is taken.
// Throughput: one beat per cycle, set by the single decode pass between the
// input register and the result register; a stalled output stalls the input.
// Reset: synchronous active low; IER, LCR, FIFO pointers and count clear and
// both pipeline registers empty. FIFO storage is not cleared.
module uart_16550_register_file_core import u16550_pkg::*; #(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_address,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_push_accepted,
    output logic       o_irq_pulse,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte
);

    logic       r_in_valid;
    logic [1:0] r_mode;
    logic [2:0] r_address;
    logic [7:0] r_write_data;
    logic       r_out_valid;
    logic [7:0] r_read_data;
    logic       r_push_accepted;
    logic       r_irq_pulse;
    logic       r_tx_valid;
    logic [7:0] r_tx_byte;

    logic       advance;
    t_fifo_req  fifo_req;
    t_fifo_stat fifo_stat;
    logic [7:0] read_data;
    logic       push_accepted;
    logic       irq_pulse;
    logic       tx_valid;
    logic [7:0] tx_byte;

    // The registered beat moves on when the result register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode       <= i_mode;
            r_address    <= i_address;
            r_write_data <= i_write_data;
        end
    end

    u16550_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (advance),
        .i_mode          (r_mode),
        .i_address       (r_address),
        .i_write_data    (r_write_data),
        .i_fifo_stat     (fifo_stat),
        .o_fifo_req      (fifo_req),
        .o_read_data     (read_data),
        .o_push_accepted (push_accepted),
        .o_irq_pulse     (irq_pulse),
        .o_tx_valid      (tx_valid),
        .o_tx_byte       (tx_byte)
    );

    u16550_rx_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fifo_req),
        .o_stat  (fifo_stat)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data     <= read_data;
            r_push_accepted <= push_accepted;
            r_irq_pulse     <= irq_pulse;
            r_tx_valid      <= tx_valid;
            r_tx_byte       <= tx_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_push_accepted = r_push_accepted;
    assign o_irq_pulse     = r_irq_pulse;
    assign o_tx_valid      = r_tx_valid;
    assign o_tx_byte       = r_tx_byte;

    // The input side only stalls when both pipeline registers are occupied.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled while the pipeline had room");

    // An accepted push never also reads or transmits.
    a_push_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_push_accepted) |-> (o_read_data == 8'h00 && !o_tx_valid))
        else $error("push result carries read or transmit data");

    // The FIFO never pushes and pops in the same cycle.
    a_fifo_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_req.push && fifo_req.pop))
        else $error("simultaneous FIFO push and pop");

    // A beat always lands in the result register in the cycle after it advances.
    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed beat did not reach the result register");

endmodule

@@ sim/tb_uart_16550_register_file_core.sv @@
// Self-checking testbench for the UART register file core: directed table, then random traffic.
module tb_uart_16550_register_file_core import u16550_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RX_DEPTH    = DEFAULT_FIFO_DEPTH;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] read_data;
        logic       push_accepted;
        logic       irq_pulse;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } t_reg_resp;

    // One row of the directed table; fixed_resp is used only when has_fixed is set.
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] addr;
        logic [7:0] data;
        int         reps;
        bit         has_fixed;
        t_reg_resp  fixed_resp;
    } t_access_row;

    localparam t_reg_resp ZERO_RESP = '0;

    localparam int N_ROWS = 29;
    localparam t_access_row ACCESS_ROWS [N_ROWS] = '{
        '{MODE_READ,   ADDR_IIR, 8'h00, 1,  1'b1, '{IIR_NONE, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{MODE_READ,   ADDR_LSR, 8'h00, 1,  1'b1,
          '{LSR_TEMT | LSR_THRE, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{MODE_READ,   ADDR_RBR, 8'h00, 1,  1'b1, ZERO_RESP},
        '{MODE_UNUSED, ADDR_SCR, 8'hFF, 1,  1'b1, ZERO_RESP},
        '{MODE_WRITE,  ADDR_LCR, 8'h80, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_RBR, 8'h00, 1,  1'b1, ZERO_RESP},
        '{MODE_WRITE,  ADDR_IER, 8'hFF, 1,  1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_RBR, 8'hFF, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_IER, 8'h00, 1,  1'b1, ZERO_RESP},
        '{MODE_READ,   ADDR_LCR, 8'h00, 1,  1'b1, '{8'h80, 1'b0, 1'b0, 1'b0, 8'h00}},
        '{MODE_WRITE,  ADDR_LCR, 8'h7F, 1,  1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_RBR, 8'hFF, 1,  1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_RBR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_IER, 8'h01, 1,  1'b0, ZERO_RESP},
        '{MODE_PUSH,   ADDR_SCR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_PUSH,   ADDR_RBR, 8'hFF, 15, 1'b0, ZERO_RESP},
        '{MODE_PUSH,   ADDR_LSR, 8'h5A, 1,  1'b1, ZERO_RESP},
        '{MODE_READ,   ADDR_IIR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_LSR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_RBR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_IER, 8'h02, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_IIR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_SCR, 8'hFF, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_SCR, 8'h00, 1,  1'b1, ZERO_RESP},
        '{MODE_READ,   ADDR_MSR, 8'h00, 1,  1'b1, ZERO_RESP},
        '{MODE_WRITE,  ADDR_IER, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_RBR, 8'h00, 16, 1'b0, ZERO_RESP},
        '{MODE_WRITE,  ADDR_LCR, 8'h00, 1,  1'b0, ZERO_RESP},
        '{MODE_READ,   ADDR_MCR, 8'h00, 1,  1'b1, ZERO_RESP}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_mode = '0;
    logic [2:0] i_address = '0;
    logic [7:0] i_write_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_read_data;
    logic       o_push_accepted;
    logic       o_irq_pulse;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;

    // Shadow copy of the register and receive FIFO state.
    logic [7:0] ier_shadow;
    logic [7:0] lcr_shadow;
    logic [7:0] rx_bytes [RX_DEPTH];
    int         rx_head;
    int         rx_tail;
    int         rx_fill;

    t_reg_resp  awaited_resp [$];
    int         err_count = 0;
    int         taken_count = 0;
    int         hold_left = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    uart_16550_register_file_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_push_accepted(o_push_accepted),
        .o_irq_pulse    (o_irq_pulse),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Interrupt request: receive data pending with its enable, or transmit-empty enabled.
    function automatic logic irq_due();
        return (ier_shadow[IER_RX_READY_BIT] && rx_fill != 0) || ier_shadow[IER_TX_EMPTY_BIT];
    endfunction

    // Applies one bus access or receive push to the shadow state and returns its result.
    function automatic t_reg_resp apply_uart_access(input logic [1:0] mode,
                                                    input logic [2:0] addr,
                                                    input logic [7:0] data);
        t_reg_resp r;
        logic      dlab;
        r = '0;
        dlab = lcr_shadow[LCR_DLAB_BIT];
        case (mode)
            MODE_READ: begin
                case (addr)
                    ADDR_RBR: begin
                        if (!dlab && rx_fill != 0) begin
                            r.read_data = rx_bytes[rx_head];
                            rx_head = (rx_head + 1) % RX_DEPTH;
                            rx_fill--;
                        end
                    end
                    ADDR_IER: r.read_data = dlab ? 8'h00 : ier_shadow;
                    ADDR_IIR: begin
                        if (rx_fill != 0 && ier_shadow[IER_RX_READY_BIT]) begin
                            r.read_data = IIR_RX_READY;
                        end else if (ier_shadow[IER_TX_EMPTY_BIT]) begin
                            r.read_data = IIR_TX_EMPTY;
                        end else begin
                            r.read_data = IIR_NONE;
                        end
                    end
                    ADDR_LCR: r.read_data = lcr_shadow;
                    ADDR_LSR: r.read_data = LSR_TEMT | LSR_THRE |
                                            ((rx_fill != 0) ? LSR_DR : 8'h00);
                    default:  r.read_data = 8'h00;
                endcase
            end
            MODE_WRITE: begin
                if (addr == ADDR_RBR && !dlab) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = data;
                end else if (addr == ADDR_IER && !dlab) begin
                    ier_shadow  = data;
                    r.irq_pulse = irq_due();
                end else if (addr == ADDR_LCR) begin
                    lcr_shadow = data;
                end
            end
            MODE_PUSH: begin
                // A push into a full FIFO is dropped without an interrupt.
                if (rx_fill < RX_DEPTH) begin
                    rx_bytes[rx_tail] = data;
                    rx_tail = (rx_tail + 1) % RX_DEPTH;
                    rx_fill++;
                    r.push_accepted = 1'b1;
                    r.irq_pulse     = irq_due();
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one beat, waits for it to be taken, records its result, then maybe idles.
    task automatic send_access(input logic [1:0] mode, input logic [2:0] addr,
                               input logic [7:0] data, input bit has_fixed,
                               input t_reg_resp fixed_resp);
        t_reg_resp r;
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_write_data <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = apply_uart_access(mode, addr, data);
        awaited_resp.push_back(has_fixed ? fixed_resp : r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Random beat; push_pct steers the FIFO toward filling or draining.
    task automatic send_random_access(input int push_pct);
        logic [1:0] m;
        logic [2:0] a;
        logic [7:0] d;
        int         pick;
        a = 3'($urandom_range(7));
        d = 8'($urandom_range(255));
        if ($urandom_range(99) < push_pct) begin
            m = MODE_PUSH;
        end else begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                m = MODE_READ;
                a = ADDR_RBR;
            end else if (pick < 55) begin
                m = MODE_READ;
            end else if (pick < 67) begin
                m = MODE_WRITE;
                a = ADDR_RBR;
            end else if (pick < 77) begin
                m = MODE_WRITE;
                a = ADDR_IER;
            end else if (pick < 85) begin
                // Keep the divisor latch bit mostly clear so the data path stays reachable.
                m = MODE_WRITE;
                a = ADDR_LCR;
                if ($urandom_range(3) != 0) d[LCR_DLAB_BIT] = 1'b0;
            end else if (pick < 96) begin
                m = MODE_WRITE;
            end else begin
                m = MODE_UNUSED;
            end
        end
        send_access(m, a, d, 1'b0, ZERO_RESP);
    endtask

    // Holds the input quiet until every pending result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_resp.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check each beat taken against the oldest pending result.
    always @(posedge i_clk) begin
        t_reg_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_resp.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = awaited_resp.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", o_read_data, want.read_data);
                if (o_push_accepted !== want.push_accepted)
                    report_mismatch("push_accepted", o_push_accepted, want.push_accepted);
                if (o_irq_pulse !== want.irq_pulse)
                    report_mismatch("irq_pulse", o_irq_pulse, want.irq_pulse);
                if (o_tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", o_tx_valid, want.tx_valid);
                if (o_tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", o_tx_byte, want.tx_byte);
            end
        end
    end

    // Receiver pacing: random idling, plus long back-pressure stretches so the
    // pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            taken_count++;
            if (taken_count == 300 || taken_count == 1000) hold_left = 64;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus: reset, directed table, then three phases of random traffic at different idle rates.
    initial begin
        ier_shadow = '0;
        lcr_shadow = '0;
        rx_head    = 0;
        rx_tail    = 0;
        rx_fill    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 50;
        for (int row = 0; row < N_ROWS; row++) begin
            for (int k = 0; k < ACCESS_ROWS[row].reps; k++) begin
                send_access(ACCESS_ROWS[row].mode, ACCESS_ROWS[row].addr,
                            ACCESS_ROWS[row].data, ACCESS_ROWS[row].has_fixed,
                            ACCESS_ROWS[row].fixed_resp);
            end
        end
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 21 : 0;
            for (int n = 0; n < 430; n++) begin
                send_random_access(((n / 40) % 2 == 0) ? 70 : 15);
            end
            drain_results();
        end

        // Let any stray beat surface before the verdict.
        repeat (8) @(posedge i_clk);
        if (awaited_resp.size() != 0)
            report_mismatch("results never produced", awaited_resp.size(), 0);
        if (err_count == 0) begin
            $display("uart_16550_register_file_core test passed");
        end else begin
            $display("uart_16550_register_file_core test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("uart_16550_register_file_core test failed");
        $finish;
    end

endmodule
